// ===== src/stq_pkg.sv =====
// Shared types, constants and helpers of the sorted timer queue engine.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

    localparam int NUM_TIMERS  = 256;
    localparam int TIMER_W     = 8;
    localparam int NUM_CPUS    = 16;
    localparam int CPU_W       = 4;
    localparam int NUM_BASES   = 4;
    localparam int BASE_W      = 2;
    localparam int NUM_QUEUES  = NUM_CPUS * NUM_BASES;
    localparam int Q_W         = CPU_W + BASE_W;
    localparam int LINK_W      = TIMER_W + 1;
    localparam int MAX_EXPIRE  = 64;
    localparam int N_W         = 7;
    localparam int CNT_W       = 9;
    localparam int STAT_W      = 32;
    localparam int TIME_W      = 64;
    localparam int ACT_W       = 5;
    localparam int THR_W       = 8;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TIMERS);

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_TICK    = 2'd2,
        OP_MIGRATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_ABS    = 2'd0,
        MODE_REL    = 2'd1,
        MODE_PINNED = 2'd2,
        MODE_SOFT   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_NEVER   = 3'd1,
        STATUS_QUEUED  = 3'd2,
        STATUS_NO_MIG  = 3'd3,
        STATUS_NO_EXP  = 3'd4
    } status_t;

    typedef enum logic {
        CFG_ACTIVE_CPUS = 1'b0,
        CFG_THRESHOLD   = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef struct packed {
        op_t                 operation;
        logic [TIMER_W-1:0]  timer_id;
        logic [BASE_W-1:0]   clock_base;
        logic [1:0]          timer_mode;
        logic [TIME_W-1:0]   expiry_time;
        logic [CPU_W-1:0]    chosen_cpu;
        logic                restart_on_expiry;
        logic [TIME_W-1:0]   current_time;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [TIMER_W-1:0]  result_timer;
        logic [CPU_W-1:0]    result_cpu;
        logic [BASE_W-1:0]   result_base;
        logic [TIME_W-1:0]   lateness;
        logic                was_restarted;
        logic                last_result;
        logic [CNT_W-1:0]    active_count;
        logic [STAT_W-1:0]   expired_count;
        logic [STAT_W-1:0]   migration_count;
        logic [STAT_W-1:0]   started_count;
    } result_t;

    typedef struct packed {
        logic [BASE_W-1:0]   base;
        logic [CPU_W-1:0]    cpu;
        logic                restart;
        logic                pinned;
        logic                started;
        logic                active;
    } attr_t;

    localparam int ATTR_W = $bits(attr_t);

    function automatic result_t mk_result(
        input status_t             st,
        input logic [TIMER_W-1:0]  tmr,
        input logic [CPU_W-1:0]    cpu,
        input logic [BASE_W-1:0]   base,
        input logic [TIME_W-1:0]   late,
        input logic                rs,
        input logic                last,
        input logic [CNT_W-1:0]    act,
        input logic [STAT_W-1:0]   exp_n,
        input logic [STAT_W-1:0]   mig_n,
        input logic [STAT_W-1:0]   start_n
    );
        result_t r;
        r.status          = st;
        r.result_timer    = tmr;
        r.result_cpu      = cpu;
        r.result_base     = base;
        r.lateness        = late;
        r.was_restarted   = rs;
        r.last_result     = last;
        r.active_count    = act;
        r.expired_count   = exp_n;
        r.migration_count = mig_n;
        r.started_count   = start_n;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/stq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/stq_alu.sv =====
// Shared 64-bit add/subtract unit with carry or borrow out.
`timescale 1ns / 1ps
`default_nettype none
module stq_alu (
    input  stq_pkg::alu_op_t              op,
    input  wire logic [stq_pkg::TIME_W-1:0] a,
    input  wire logic [stq_pkg::TIME_W-1:0] b,
    output logic      [stq_pkg::TIME_W-1:0] result,
    output logic                            carry
);
    import stq_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_ADD: {carry, result} = {1'b0, a} + {1'b0, b};
            ALU_SUB: {carry, result} = {1'b0, a} - {1'b0, b};
            default: {carry, result} = {1'b0, a} + {1'b0, b};
        endcase
    end

endmodule
`default_nettype wire

// ===== src/sorted_timer_queue_engine.sv =====
// Top level of the sorted timer queue engine: sequencer, tables and counters.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Command channel: drive request and raise start while busy is low; the
//   command is taken at that edge and busy rises on the next cycle. Ops are
//   start, cancel, tick and migrate.
//   Result channel: every result shows on result for exactly one cycle with
//   result_valid high. The receiver cannot stall; results are never held.
//   A tick gives one result per expired timer (up to 64), the last marked by
//   last_result; every other command gives exactly one result.
//   Config channel: cfg_valid/cfg_index/cfg_data, cfg_ready always high.
//   Write only while busy is low.
// Operation:
//   Each queue is a linked list walked one RAM read per element, each
//   element taking an issue step and a compare step. A start reads the
//   timer's attributes, selects a CPU unless pinned and already started,
//   and walks the queued entries ahead of the new timer. A cancel walks its
//   queue once; a migrate scans active_cpus counts then walks the source
//   queue up to twice plus the destination once. A tick drains due heads
//   queue by queue, re-inserting periodic timers. One command at a time.
// Reset:
//   All queues empty, timers never started, counters zero, active_cpus 8,
//   imbalance_threshold 2. Valid bits clear the tables at once; no sweep.
module sorted_timer_queue_engine (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  stq_pkg::request_t         request,
    output logic                      result_valid,
    output stq_pkg::result_t          result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data
);
    import stq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_ATTR_W, ST_MOD, ST_SWRITE, ST_SFIN, ST_S_EMIT,
        ST_CFIN, ST_C_EMIT,
        ST_I_HEAD, ST_I_HW, ST_I_CHK, ST_I_CMP, ST_I_LINK, ST_I_PREV,
        ST_R_HEAD, ST_R_HW, ST_R_CHK, ST_R_STEP,
        ST_T_HEAD, ST_T_HW, ST_T_CMP, ST_T_RS, ST_T_EXP, ST_T_EMIT,
        ST_T_NEXTQ, ST_T_DONE,
        ST_M_SCAN, ST_M_DEC, ST_M_BASE, ST_M_HW, ST_M_CHK, ST_M_AT,
        ST_M_MV, ST_M_MVW, ST_M_FIN, ST_M_FIN2, ST_M_EMIT
    } state_t;

    // configuration
    logic [ACT_W-1:0] act_cfg_reg;
    logic [THR_W-1:0] thr_reg;
    logic [ACT_W-1:0] act_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_cfg_reg <= ACT_W'(8);
            thr_reg     <= THR_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE_CPUS: act_cfg_reg <= cfg_data[ACT_W-1:0];
                CFG_THRESHOLD:   thr_reg     <= cfg_data;
                default:         thr_reg     <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        if (act_cfg_reg == '0)
            act_eff = ACT_W'(1);
        else if (act_cfg_reg > ACT_W'(NUM_CPUS))
            act_eff = ACT_W'(NUM_CPUS);
        else
            act_eff = act_cfg_reg;
    end

    // tables
    logic                exp_we, per_we, link_we, attr_we, head_we;
    logic [TIMER_W-1:0]  exp_waddr, per_waddr, link_waddr, attr_waddr;
    logic [TIMER_W-1:0]  exp_raddr, per_raddr, link_raddr, attr_raddr;
    logic [Q_W-1:0]      head_waddr, head_raddr;
    logic [TIME_W-1:0]   exp_wdata, per_wdata, exp_rd, per_rd;
    logic [LINK_W-1:0]   link_wdata, link_rd, head_wdata, head_raw, head_rd;
    logic [ATTR_W-1:0]   attr_wdata, attr_raw;
    attr_t               attr_rd;

    logic [NUM_TIMERS-1:0] attr_vld_reg;
    logic [NUM_QUEUES-1:0] head_vld_reg;
    logic                  attr_rv_reg, head_rv_reg;

    stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TIME_W)) u_exp_ram (
        .clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_wdata),
        .raddr(exp_raddr), .rdata(exp_rd));
    stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TIME_W)) u_per_ram (
        .clk(clk), .we(per_we), .waddr(per_waddr), .wdata(per_wdata),
        .raddr(per_raddr), .rdata(per_rd));
    stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(LINK_W)) u_link_ram (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rd));
    stq_ram #(.DEPTH(NUM_TIMERS), .WIDTH(ATTR_W)) u_attr_ram (
        .clk(clk), .we(attr_we), .waddr(attr_waddr), .wdata(attr_wdata),
        .raddr(attr_raddr), .rdata(attr_raw));
    stq_ram #(.DEPTH(NUM_QUEUES), .WIDTH(LINK_W)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_raw));

    // Unwritten entries read as their reset value: inactive attrs, empty heads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_vld_reg <= '0;
            head_vld_reg <= '0;
            attr_rv_reg  <= 1'b0;
            head_rv_reg  <= 1'b0;
        end
        else
        begin
            if (attr_we)
                attr_vld_reg[attr_waddr] <= 1'b1;
            if (head_we)
                head_vld_reg[head_waddr] <= 1'b1;
            attr_rv_reg <= attr_vld_reg[attr_raddr];
            head_rv_reg <= head_vld_reg[head_raddr];
        end
    end

    assign attr_rd = attr_t'(attr_rv_reg ? attr_raw : '0);
    assign head_rd = head_rv_reg ? head_raw : NIL;

    // shared arithmetic unit
    alu_op_t           alu_op;
    logic [TIME_W-1:0] alu_a, alu_b, alu_res;
    logic              alu_c;

    stq_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .result(alu_res),
                   .carry(alu_c));

    // counters
    logic [CNT_W-1:0]  cnt_reg [NUM_CPUS];
    logic [CNT_W-1:0]  total_reg;
    logic [STAT_W-1:0] expired_reg, migrated_reg, started_reg;
    logic [CPU_W-1:0]  cnt_idx;
    cnt_op_t           cnt_op, total_op;
    logic              exp_inc, mig_inc, start_inc;
    logic [CNT_W-1:0]  cnt_rd;

    assign cnt_rd = cnt_reg[cnt_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
                cnt_reg[i] <= '0;
            total_reg    <= '0;
            expired_reg  <= '0;
            migrated_reg <= '0;
            started_reg  <= '0;
        end
        else
        begin
            unique case (cnt_op)
                CNT_INC:  cnt_reg[cnt_idx] <= cnt_rd + CNT_W'(1);
                CNT_DEC:  cnt_reg[cnt_idx] <= cnt_rd - CNT_W'(1);
                default:  cnt_reg[cnt_idx] <= cnt_rd;
            endcase
            unique case (total_op)
                CNT_INC:  total_reg <= total_reg + CNT_W'(1);
                CNT_DEC:  total_reg <= total_reg - CNT_W'(1);
                default:  total_reg <= total_reg;
            endcase
            if (exp_inc && expired_reg != '1)
                expired_reg <= expired_reg + STAT_W'(1);
            if (mig_inc && migrated_reg != '1)
                migrated_reg <= migrated_reg + STAT_W'(1);
            if (start_inc && started_reg != '1)
                started_reg <= started_reg + STAT_W'(1);
        end
    end

    // sequencer registers
    state_t             state_reg, state_next, ret_reg, ret_next;
    op_t                op_reg, op_next;
    logic [TIMER_W-1:0] id_reg, id_next, tid_reg, tid_next;
    logic [BASE_W-1:0]  bs_reg, bs_next;
    logic [CPU_W-1:0]   cpu_reg, cpu_next, chosen_reg, chosen_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic               pinned_reg, pinned_next, rs_in_reg, rs_in_next;
    logic [TIME_W-1:0]  exp_in_reg, exp_in_next, now_reg, now_next;
    logic [TIME_W-1:0]  key_reg, key_next, per_reg, per_next;
    logic [TIME_W-1:0]  late_reg, late_next;
    logic [LINK_W-1:0]  cur_reg, cur_next, prev_reg, prev_next;
    attr_t              attr_reg, attr_next;
    logic [ACT_W-1:0]   mod_reg, mod_next, scan_reg, scan_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]   max_n_reg, max_n_next, min_n_reg, min_n_next;
    logic [CPU_W-1:0]   max_cpu_reg, max_cpu_next, min_cpu_reg, min_cpu_next;
    logic               pend_vld_reg, pend_vld_next;
    result_t            pend_reg, pend_next, out_reg, out_next;
    logic               strobe_reg, strobe_next;
    attr_t              attr_new;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = strobe_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        tid_reg     <= tid_next;
        bs_reg      <= bs_next;
        cpu_reg     <= cpu_next;
        chosen_reg  <= chosen_next;
        q_reg       <= q_next;
        pinned_reg  <= pinned_next;
        rs_in_reg   <= rs_in_next;
        exp_in_reg  <= exp_in_next;
        now_reg     <= now_next;
        key_reg     <= key_next;
        per_reg     <= per_next;
        late_reg    <= late_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        attr_reg    <= attr_next;
        mod_reg     <= mod_next;
        scan_reg    <= scan_next;
        max_n_reg   <= max_n_next;
        min_n_reg   <= min_n_next;
        max_cpu_reg <= max_cpu_next;
        min_cpu_reg <= min_cpu_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        tid_next      = tid_reg;
        bs_next       = bs_reg;
        cpu_next      = cpu_reg;
        chosen_next   = chosen_reg;
        q_next        = q_reg;
        pinned_next   = pinned_reg;
        rs_in_next    = rs_in_reg;
        exp_in_next   = exp_in_reg;
        now_next      = now_reg;
        key_next      = key_reg;
        per_next      = per_reg;
        late_next     = late_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        attr_next     = attr_reg;
        mod_next      = mod_reg;
        scan_next     = scan_reg;
        n_next        = n_reg;
        max_n_next    = max_n_reg;
        min_n_next    = min_n_reg;
        max_cpu_next  = max_cpu_reg;
        min_cpu_next  = min_cpu_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        strobe_next   = 1'b0;

        exp_we = 1'b0;  exp_waddr  = tid_reg; exp_wdata  = key_reg; exp_raddr  = tid_reg;
        per_we = 1'b0;  per_waddr  = tid_reg; per_wdata  = key_reg; per_raddr  = tid_reg;
        link_we = 1'b0; link_waddr = tid_reg; link_wdata = cur_reg; link_raddr = tid_reg;
        attr_we = 1'b0; attr_waddr = tid_reg; attr_wdata = attr_reg; attr_raddr = tid_reg;
        head_we = 1'b0; head_waddr = q_reg;   head_wdata = cur_reg; head_raddr = q_reg;

        alu_op = ALU_SUB;
        alu_a  = key_reg;
        alu_b  = exp_rd;

        cnt_idx   = cpu_reg;
        cnt_op    = CNT_HOLD;
        total_op  = CNT_HOLD;
        exp_inc   = 1'b0;
        mig_inc   = 1'b0;
        start_inc = 1'b0;

        attr_new = attr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = request.operation;
                    id_next     = request.timer_id;
                    tid_next    = request.timer_id;
                    bs_next     = request.clock_base;
                    pinned_next = (mode_t'(request.timer_mode) == MODE_PINNED);
                    rs_in_next  = request.restart_on_expiry;
                    exp_in_next = request.expiry_time;
                    now_next    = request.current_time;
                    chosen_next = request.chosen_cpu;
                    attr_raddr  = request.timer_id;
                    unique case (request.operation)
                        OP_START, OP_CANCEL:
                            state_next = ST_ATTR_W;
                        OP_TICK:
                        begin
                            cpu_next      = '0;
                            bs_next       = '0;
                            n_next        = '0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_T_HEAD;
                        end
                        default:
                        begin
                            scan_next    = '0;
                            max_n_next   = '0;
                            min_n_next   = '1;
                            max_cpu_next = '0;
                            min_cpu_next = '0;
                            state_next   = ST_M_SCAN;
                        end
                    endcase
                end
            end

            ST_ATTR_W:
            begin
                attr_next = attr_rd;
                if (op_reg == OP_START)
                begin
                    if (attr_rd.active)
                    begin
                        out_next = mk_result(STATUS_QUEUED, id_reg, attr_rd.cpu,
                            attr_rd.base, '0, 1'b0, 1'b1, total_reg, expired_reg,
                            migrated_reg, started_reg);
                        strobe_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (pinned_reg && attr_rd.started)
                    begin
                        cpu_next   = attr_rd.cpu;
                        state_next = ST_SWRITE;
                    end
                    else
                    begin
                        mod_next   = {1'b0, chosen_reg};
                        state_next = ST_MOD;
                    end
                end
                else if (!attr_rd.started)
                begin
                    out_next = mk_result(STATUS_NEVER, id_reg, '0, '0, '0, 1'b0,
                        1'b1, total_reg, expired_reg, migrated_reg, started_reg);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (attr_rd.active)
                begin
                    cpu_next   = attr_rd.cpu;
                    bs_next    = attr_rd.base;
                    q_next     = {attr_rd.cpu, attr_rd.base};
                    ret_next   = ST_CFIN;
                    state_next = ST_R_HEAD;
                end
                else
                begin
                    out_next = mk_result(STATUS_OK, id_reg, attr_rd.cpu, attr_rd.base,
                        '0, 1'b0, 1'b1, total_reg, expired_reg, migrated_reg,
                        started_reg);
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            // reduce chosen_cpu modulo the active CPU count by repeated subtract
            ST_MOD:
            begin
                if (mod_reg >= act_eff)
                    mod_next = mod_reg - act_eff;
                else
                begin
                    cpu_next   = mod_reg[CPU_W-1:0];
                    state_next = ST_SWRITE;
                end
            end

            ST_SWRITE:
            begin
                attr_new.base    = bs_reg;
                attr_new.cpu     = cpu_reg;
                attr_new.restart = rs_in_reg;
                attr_new.pinned  = pinned_reg;
                attr_new.started = 1'b1;
                attr_new.active  = 1'b1;
                exp_we     = 1'b1;
                exp_waddr  = id_reg;
                exp_wdata  = exp_in_reg;
                per_we     = 1'b1;
                per_waddr  = id_reg;
                per_wdata  = exp_in_reg;
                attr_we    = 1'b1;
                attr_waddr = id_reg;
                attr_wdata = attr_new;
                key_next   = exp_in_reg;
                tid_next   = id_reg;
                q_next     = {cpu_reg, bs_reg};
                ret_next   = ST_SFIN;
                state_next = ST_I_HEAD;
            end

            ST_SFIN:
            begin
                cnt_op     = CNT_INC;
                total_op   = CNT_INC;
                start_inc  = 1'b1;
                state_next = ST_S_EMIT;
            end

            ST_S_EMIT, ST_C_EMIT:
            begin
                out_next = mk_result(STATUS_OK, id_reg, cpu_reg, bs_reg, '0, 1'b0,
                    1'b1, total_reg, expired_reg, migrated_reg, started_reg);
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_CFIN:
            begin
                attr_new.active = 1'b0;
                attr_we    = 1'b1;
                attr_waddr = id_reg;
                attr_wdata = attr_new;
                cnt_op     = CNT_DEC;
                total_op   = CNT_DEC;
                state_next = ST_C_EMIT;
            end

            // sorted insert of tid_reg with key_reg into queue q_reg
            ST_I_HEAD:
            begin
                prev_next  = NIL;
                state_next = ST_I_HW;
            end

            ST_I_HW:
            begin
                cur_next   = head_rd;
                state_next = ST_I_CHK;
            end

            ST_I_CHK:
            begin
                exp_raddr  = cur_reg[TIMER_W-1:0];
                link_raddr = cur_reg[TIMER_W-1:0];
                if (cur_reg == NIL)
                    state_next = ST_I_LINK;
                else
                    state_next = ST_I_CMP;
            end

            ST_I_CMP:
            begin
                // no borrow: entry expiry <= key, so advance behind it
                if (!alu_c)
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    state_next = ST_I_CHK;
                end
                else
                    state_next = ST_I_LINK;
            end

            ST_I_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = tid_reg;
                link_wdata = cur_reg;
                state_next = ST_I_PREV;
            end

            ST_I_PREV:
            begin
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = {1'b0, tid_reg};
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[TIMER_W-1:0];
                    link_wdata = {1'b0, tid_reg};
                end
                state_next = ret_reg;
            end

            // unlink tid_reg from queue q_reg
            ST_R_HEAD:
            begin
                prev_next  = NIL;
                state_next = ST_R_HW;
            end

            ST_R_HW:
            begin
                cur_next   = head_rd;
                state_next = ST_R_CHK;
            end

            ST_R_CHK:
            begin
                link_raddr = cur_reg[TIMER_W-1:0];
                if (cur_reg == NIL)
                    state_next = ret_reg;
                else
                    state_next = ST_R_STEP;
            end

            ST_R_STEP:
            begin
                if (cur_reg[TIMER_W-1:0] == tid_reg)
                begin
                    if (prev_reg == NIL)
                    begin
                        head_we    = 1'b1;
                        head_wdata = link_rd;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[TIMER_W-1:0];
                        link_wdata = link_rd;
                    end
                    state_next = ret_reg;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    state_next = ST_R_CHK;
                end
            end

            // tick: drain due heads queue by queue
            ST_T_HEAD:
            begin
                q_next     = {cpu_reg, bs_reg};
                head_raddr = {cpu_reg, bs_reg};
                state_next = ST_T_HW;
            end

            ST_T_HW:
            begin
                exp_raddr  = head_rd[TIMER_W-1:0];
                per_raddr  = head_rd[TIMER_W-1:0];
                attr_raddr = head_rd[TIMER_W-1:0];
                link_raddr = head_rd[TIMER_W-1:0];
                tid_next   = head_rd[TIMER_W-1:0];
                if (head_rd == NIL)
                    state_next = ST_T_NEXTQ;
                else
                    state_next = ST_T_CMP;
            end

            ST_T_CMP:
            begin
                alu_a = now_reg;
                alu_b = exp_rd;
                if (alu_c)
                    state_next = ST_T_NEXTQ;
                else
                begin
                    late_next  = alu_res;
                    key_next   = exp_rd;
                    per_next   = per_rd;
                    attr_next  = attr_rd;
                    head_we    = 1'b1;
                    head_wdata = link_rd;
                    if (attr_rd.restart)
                        state_next = ST_T_RS;
                    else
                        state_next = ST_T_EXP;
                end
            end

            ST_T_RS:
            begin
                alu_op    = ALU_ADD;
                alu_a     = key_reg;
                alu_b     = per_reg;
                exp_we    = 1'b1;
                exp_wdata = alu_c ? '1 : alu_res;
                key_next  = alu_c ? '1 : alu_res;
                ret_next  = ST_T_EMIT;
                state_next = ST_I_HEAD;
            end

            ST_T_EXP:
            begin
                attr_new.active = 1'b0;
                attr_we    = 1'b1;
                attr_wdata = attr_new;
                cnt_op     = CNT_DEC;
                total_op   = CNT_DEC;
                exp_inc    = 1'b1;
                state_next = ST_T_EMIT;
            end

            // hold each result in pend_reg so the final one can carry last_result
            ST_T_EMIT:
            begin
                if (pend_vld_reg)
                begin
                    out_next    = pend_reg;
                    strobe_next = 1'b1;
                end
                pend_next = mk_result(STATUS_OK, tid_reg, cpu_reg, bs_reg, late_reg,
                    attr_reg.restart, 1'b0, total_reg, expired_reg, migrated_reg,
                    started_reg);
                pend_vld_next = 1'b1;
                n_next        = n_reg + N_W'(1);
                if (n_reg + N_W'(1) == N_W'(MAX_EXPIRE))
                    state_next = ST_T_DONE;
                else
                    state_next = ST_T_HEAD;
            end

            ST_T_NEXTQ:
            begin
                if (bs_reg == BASE_W'(NUM_BASES - 1))
                begin
                    bs_next  = '0;
                    cpu_next = cpu_reg + CPU_W'(1);
                    if (({1'b0, cpu_reg} + ACT_W'(1)) >= act_eff)
                        state_next = ST_T_DONE;
                    else
                        state_next = ST_T_HEAD;
                end
                else
                begin
                    bs_next    = bs_reg + BASE_W'(1);
                    state_next = ST_T_HEAD;
                end
            end

            ST_T_DONE:
            begin
                if (pend_vld_reg)
                begin
                    out_next             = pend_reg;
                    out_next.last_result = 1'b1;
                end
                else
                    out_next = mk_result(STATUS_NO_EXP, '0, '0, '0, '0, 1'b0, 1'b1,
                        total_reg, expired_reg, migrated_reg, started_reg);
                strobe_next   = 1'b1;
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end

            // migrate: find fullest and emptiest CPU, one count per cycle
            ST_M_SCAN:
            begin
                cnt_idx = scan_reg[CPU_W-1:0];
                if (cnt_rd > max_n_reg)
                begin
                    max_n_next   = cnt_rd;
                    max_cpu_next = scan_reg[CPU_W-1:0];
                end
                if (cnt_rd < min_n_reg)
                begin
                    min_n_next   = cnt_rd;
                    min_cpu_next = scan_reg[CPU_W-1:0];
                end
                scan_next = scan_reg + ACT_W'(1);
                if (scan_reg + ACT_W'(1) >= act_eff)
                    state_next = ST_M_DEC;
            end

            ST_M_DEC:
            begin
                bs_next = '0;
                if ((max_n_reg - min_n_reg) > {1'b0, thr_reg})
                    state_next = ST_M_BASE;
                else
                    state_next = ST_M_EMIT;
            end

            ST_M_BASE:
            begin
                q_next     = {max_cpu_reg, bs_reg};
                head_raddr = {max_cpu_reg, bs_reg};
                state_next = ST_M_HW;
            end

            ST_M_HW:
            begin
                cur_next   = head_rd;
                state_next = ST_M_CHK;
            end

            ST_M_CHK:
            begin
                attr_raddr = cur_reg[TIMER_W-1:0];
                link_raddr = cur_reg[TIMER_W-1:0];
                if (cur_reg != NIL)
                    state_next = ST_M_AT;
                else if (bs_reg == BASE_W'(NUM_BASES - 1))
                    state_next = ST_M_EMIT;
                else
                begin
                    bs_next    = bs_reg + BASE_W'(1);
                    state_next = ST_M_BASE;
                end
            end

            ST_M_AT:
            begin
                if (!attr_rd.pinned)
                begin
                    tid_next   = cur_reg[TIMER_W-1:0];
                    attr_next  = attr_rd;
                    ret_next   = ST_M_MV;
                    state_next = ST_R_HEAD;
                end
                else
                begin
                    cur_next   = link_rd;
                    state_next = ST_M_CHK;
                end
            end

            ST_M_MV:
            begin
                attr_new.cpu = min_cpu_reg;
                attr_we      = 1'b1;
                attr_wdata   = attr_new;
                state_next   = ST_M_MVW;
            end

            ST_M_MVW:
            begin
                key_next   = exp_rd;
                q_next     = {min_cpu_reg, bs_reg};
                ret_next   = ST_M_FIN;
                state_next = ST_I_HEAD;
            end

            ST_M_FIN:
            begin
                cnt_idx    = max_cpu_reg;
                cnt_op     = CNT_DEC;
                state_next = ST_M_FIN2;
            end

            ST_M_FIN2:
            begin
                cnt_idx = min_cpu_reg;
                cnt_op  = CNT_INC;
                mig_inc = 1'b1;
                out_next = mk_result(STATUS_OK, tid_reg, min_cpu_reg, bs_reg, '0,
                    1'b0, 1'b1, total_reg, expired_reg, migrated_reg + STAT_W'(1),
                    started_reg);
                if (migrated_reg == '1)
                    out_next.migration_count = migrated_reg;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_M_EMIT:
            begin
                out_next = mk_result(STATUS_NO_MIG, '0, '0, '0, '0, 1'b0, 1'b1,
                    total_reg, expired_reg, migrated_reg, started_reg);
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    // a result only follows cycles spent working on a command
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a command in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(NUM_TIMERS))
        else $error("enqueued count above table size");

    a_tick_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(MAX_EXPIRE))
        else $error("tick expired more than the per-tick limit");

    a_pend_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("held tick result left behind at idle");
`endif

endmodule
`default_nettype wire
